FILE: hw/rtl/hie_pkg.sv
// Shared constants and types for the Hilbert index encoder.
package hie_pkg;

   localparam int COORD_W        = 32;
   localparam int INDEX_W        = 64;
   localparam int DIMS_W         = 2;
   localparam int REFL_W         = 2;
   localparam int DEF_COORD_BITS = 32;
   localparam int DEF_MAX_DIMS   = 2;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;

   localparam logic [DIMS_W-1:0] DIMS_RESET = 2'd2;

   // Register word index taken from the byte address.
   localparam logic REG_DIMS_USED = 1'b0;

   // Per-level walk state handed from one cell to the next.
   typedef struct packed {
      logic              valid;
      logic [REFL_W-1:0] refl;
      logic              rot;
   } ctl_type;

endpackage

FILE: hw/rtl/hilbert_index_encoder.sv
// Top level of the Hilbert index encoder: cell chain, result stage and register port.
// The encoder takes one point per clock while req_stall is low and registers it in each
// cell. Each bit level of the coordinates has its own cell in a chain of COORD_BITS cells;
// the reflection and rotation state walks down the chain with the point, and a final stage
// applies the marker mask and the Gray-to-binary conversion into the result register. A
// one-beat skid register behind the result register takes one more point while a result is
// stalled; req_stall comes straight from that skid register. dims_used (1 or 2, reset 2) is
// written at byte address 0 and must only change while no point is in flight.
module hilbert_index_encoder #(
   parameter int COORD_BITS = hie_pkg::DEF_COORD_BITS,
   parameter int MAX_DIMS   = hie_pkg::DEF_MAX_DIMS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [hie_pkg::COORD_W-1:0]    req_coord_0,
   input  logic [hie_pkg::COORD_W-1:0]    req_coord_1,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [hie_pkg::INDEX_W-1:0]    rsp_hilbert_index,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [hie_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [hie_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [hie_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   localparam int IDX_W = MAX_DIMS * COORD_BITS;

   logic [hie_pkg::DIMS_W-1:0] dims_ff;
   logic                       two;
   logic                       adv;

   hie_pkg::ctl_type      ctl   [0:COORD_BITS];
   logic [COORD_BITS-1:0] c0    [0:COORD_BITS];
   logic [COORD_BITS-1:0] c1    [0:COORD_BITS];
   logic [IDX_W-1:0]      idx   [0:COORD_BITS];

   logic [hie_pkg::INDEX_W-1:0] fin_idx;
   logic                        out_valid_ff, out_valid_in;
   logic [hie_pkg::INDEX_W-1:0] out_idx_ff, out_idx_in;
   logic                        skid_valid_ff, skid_valid_in;
   logic [hie_pkg::INDEX_W-1:0] skid_idx_ff, skid_idx_in;
   logic                        out_take;

   // Register port.
   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= hie_pkg::DIMS_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[2] == hie_pkg::REG_DIMS_USED)) begin
         dims_ff <= csr_pwdata[hie_pkg::DIMS_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == hie_pkg::REG_DIMS_USED) ?
                       hie_pkg::CSR_DATA_W'(dims_ff) : '0;

   // A zero count acts as one dimension and a count above MAX_DIMS as MAX_DIMS.
   assign two = (MAX_DIMS >= 2) && (dims_ff >= 2'd2);

   assign adv       = ~skid_valid_ff;
   assign req_stall = skid_valid_ff;

   assign ctl[0] = hie_pkg::ctl_type'{valid: req_valid, refl: '0, rot: 1'b0};
   assign c0[0]  = req_coord_0[COORD_BITS-1:0];
   assign c1[0]  = req_coord_1[COORD_BITS-1:0];
   assign idx[0] = '0;

   // Cell k handles bit level COORD_BITS-1-k, most significant level first.
   for (genvar k = 0; k < COORD_BITS; k++) begin : g_cell
      hie_cell #(
         .LEVEL      (COORD_BITS - 1 - k),
         .COORD_BITS (COORD_BITS),
         .IDX_W      (IDX_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .two      (two),
         .ctl_i    (ctl[k]),
         .coord0_i (c0[k]),
         .coord1_i (c1[k]),
         .idx_i    (idx[k]),
         .ctl_o    (ctl[k+1]),
         .coord0_o (c0[k+1]),
         .coord1_o (c1[k+1]),
         .idx_o    (idx[k+1])
      );
   end

   hie_finish #(
      .COORD_BITS (COORD_BITS),
      .IDX_W      (IDX_W)
   ) u_finish (
      .two     (two),
      .idx_i   (idx[COORD_BITS]),
      .index_o (fin_idx)
   );

   // Result register with a one-beat skid behind it.
   assign out_take = out_valid_ff & ~rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_idx_in    = out_idx_ff;
      skid_valid_in = skid_valid_ff;
      skid_idx_in   = skid_idx_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_valid_in  = 1'b1;
            out_idx_in    = skid_idx_ff;
            skid_valid_in = 1'b0;
         end
      end else if (ctl[COORD_BITS].valid) begin
         if (!out_valid_ff || out_take) begin
            out_valid_in = 1'b1;
            out_idx_in   = fin_idx;
         end else begin
            skid_valid_in = 1'b1;
            skid_idx_in   = fin_idx;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_idx_ff  <= out_idx_in;
      skid_idx_ff <= skid_idx_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_hilbert_index = out_idx_ff;

   // The skid register only fills behind a waiting result.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a beat while the result register is empty");

   a_skid_catches: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall && !skid_valid_ff && ctl[COORD_BITS].valid) |=> skid_valid_ff)
      else $error("finished beat was not caught by the skid register");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_stall) |=> (skid_valid_ff && $stable(skid_idx_ff)))
      else $error("skid register lost or changed its beat while stalled");

   a_chain_frozen: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |=> $stable(ctl[COORD_BITS]))
      else $error("cell chain moved while the skid register was full");

endmodule

FILE: hw/rtl/hie_cell.sv
// One bit level of the Hilbert walk: gathers coordinate bits, places index bits, updates state.
module hie_cell #(
   parameter int LEVEL      = 0,
   parameter int COORD_BITS = hie_pkg::DEF_COORD_BITS,
   parameter int IDX_W      = hie_pkg::DEF_MAX_DIMS * hie_pkg::DEF_COORD_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  two,
   input  hie_pkg::ctl_type      ctl_i,
   input  logic [COORD_BITS-1:0] coord0_i,
   input  logic [COORD_BITS-1:0] coord1_i,
   input  logic [IDX_W-1:0]      idx_i,
   output hie_pkg::ctl_type      ctl_o,
   output logic [COORD_BITS-1:0] coord0_o,
   output logic [COORD_BITS-1:0] coord1_o,
   output logic [IDX_W-1:0]      idx_o
);

   hie_pkg::ctl_type              ctl_ff, ctl_in;
   logic [COORD_BITS-1:0]         coord0_ff, coord1_ff;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic [hie_pkg::REFL_W-1:0]    new_refl, bits, rbits;
   logic [IDX_W-1:0]              placed;

   always_comb begin
      new_refl = {two & coord1_i[LEVEL], coord0_i[LEVEL]};
      bits     = ctl_i.refl ^ new_refl;
      // With two dimensions a rotation of one swaps the pair of bits.
      rbits    = (two && ctl_i.rot) ? {bits[0], bits[1]} : bits;
      if (two) begin
         placed = IDX_W'(rbits) << (2 * LEVEL);
      end else begin
         placed = IDX_W'(rbits) << LEVEL;
      end
      idx_in       = idx_i | placed;
      ctl_in.valid = ctl_i.valid;
      ctl_in.refl  = new_refl ^ (ctl_i.rot ? 2'b10 : 2'b01);
      // The rotation steps by one, plus one more when the low bit is set, modulo two.
      ctl_in.rot   = two & (ctl_i.rot ^ ~rbits[0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         coord0_ff <= coord0_i;
         coord1_ff <= coord1_i;
         idx_ff    <= idx_in;
      end
   end

   assign ctl_o    = ctl_ff;
   assign coord0_o = coord0_ff;
   assign coord1_o = coord1_ff;
   assign idx_o    = idx_ff;

endmodule

FILE: hw/rtl/hie_finish.sv
// Final step of the encoder: marker mask and Gray-to-binary prefix XOR.
module hie_finish #(
   parameter int COORD_BITS = hie_pkg::DEF_COORD_BITS,
   parameter int IDX_W      = hie_pkg::DEF_MAX_DIMS * hie_pkg::DEF_COORD_BITS
) (
   input  logic                        two,
   input  logic [IDX_W-1:0]            idx_i,
   output logic [hie_pkg::INDEX_W-1:0] index_o
);

   // Lower-group marker: every dims-th bit below the top group, shifted down by one.
   function automatic logic [hie_pkg::INDEX_W-1:0] marker_mask(input int cbits,
                                                               input bit dual);
      logic [hie_pkg::INDEX_W-1:0] m;
      m = '0;
      for (int i = 0; i < hie_pkg::INDEX_W; i++) begin
         if (dual) begin
            m[i] = ((i & 1) == 1) && (i < 2 * cbits - 2);
         end else begin
            m[i] = (i < cbits - 1);
         end
      end
      return m;
   endfunction

   localparam logic [hie_pkg::INDEX_W-1:0] MARK_ONE = marker_mask(COORD_BITS, 1'b0);
   localparam logic [hie_pkg::INDEX_W-1:0] MARK_TWO = marker_mask(COORD_BITS, 1'b1);

   logic [hie_pkg::INDEX_W-1:0] g;

   always_comb begin
      g = hie_pkg::INDEX_W'(idx_i) ^ (two ? MARK_TWO : MARK_ONE);
      for (int s = 1; s < hie_pkg::INDEX_W; s = s * 2) begin
         g = g ^ (g >> s);
      end
      index_o = g;
   end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Hilbert index encoder: random and directed points.
module tb_top;

   localparam logic [hie_pkg::CSR_ADDR_W-1:0] DIMS_ADDR   = {hie_pkg::REG_DIMS_USED, 2'b00};
   localparam logic [hie_pkg::CSR_ADDR_W-1:0] UNUSED_ADDR = {~hie_pkg::REG_DIMS_USED, 2'b00};
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_POINTS  = 125;
   localparam int DRAIN_CYCLES  = 2 * (hie_pkg::COORD_W + 1);

   // Holds the encoder's register copy and the Hilbert indexes still owed by the block.
   class index_tracker_type;
      logic [hie_pkg::DIMS_W-1:0]  dims = hie_pkg::DIMS_RESET;
      logic [hie_pkg::INDEX_W-1:0] pending_index[$];
      int mismatches = 0;
      int checked = 0;

      function logic [hie_pkg::INDEX_W-1:0] low_ones(int unsigned n);
         if (n >= hie_pkg::INDEX_W) return '1;
         return (64'd1 << n) - 64'd1;
      endfunction

      function void write_reg(logic [hie_pkg::CSR_ADDR_W-1:0] addr,
                              logic [hie_pkg::CSR_DATA_W-1:0] data);
         if (addr == DIMS_ADDR) dims = data[hie_pkg::DIMS_W-1:0];
      endfunction

      // Moore's walk over the bit levels, then the marker mask and the Gray-to-binary fold.
      function logic [hie_pkg::INDEX_W-1:0] hilbert_index_of(
            logic [hie_pkg::COORD_W-1:0] c0,
            logic [hie_pkg::COORD_W-1:0] c1);
         int unsigned nd;
         int unsigned rot;
         logic [hie_pkg::INDEX_W-1:0] refl, bits, idx, lowest, mask;
         nd = (dims == 0) ? 1 : ((dims > 2) ? 2 : dims);
         mask = low_ones(nd);
         refl = '0;
         idx = '0;
         rot = 0;
         for (int b = hie_pkg::COORD_W - 1; b >= 0; b--) begin
            bits = refl;
            refl = '0;
            refl[0] = c0[b];
            if (nd == 2) refl[1] = c1[b];
            bits = (bits ^ refl) & mask;
            if (rot != 0 && rot < nd) bits = ((bits >> rot) | (bits << (nd - rot))) & mask;
            idx |= bits << (nd * b);
            refl ^= 64'd1 << rot;
            lowest = bits & (~bits + 64'd1) & low_ones(nd - 1);
            while (lowest != 0) begin
               lowest >>= 1;
               rot++;
            end
            rot++;
            while (rot >= nd) rot -= nd;
         end
         idx ^= (low_ones(nd * hie_pkg::COORD_W) / low_ones(nd)) >> 1;
         for (int unsigned d = 1; d < hie_pkg::INDEX_W; d *= 2) idx ^= idx >> d;
         return idx;
      endfunction

      function void note_point(logic [hie_pkg::COORD_W-1:0] c0,
                               logic [hie_pkg::COORD_W-1:0] c1);
         pending_index.push_back(hilbert_index_of(c0, c1));
      endfunction

      function void check_index(logic [hie_pkg::INDEX_W-1:0] actual);
         logic [hie_pkg::INDEX_W-1:0] want;
         if (pending_index.size() == 0) begin
            $error("unexpected beat: hilbert_index actual %h", actual);
            mismatches++;
            return;
         end
         want = pending_index.pop_front();
         checked++;
         if (actual !== want) begin
            $error("hilbert_index expected %h actual %h", want, actual);
            mismatches++;
         end
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic [hie_pkg::COORD_W-1:0]    req_coord_0;
   logic [hie_pkg::COORD_W-1:0]    req_coord_1;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic [hie_pkg::INDEX_W-1:0]    rsp_hilbert_index;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [hie_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [hie_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [hie_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   index_tracker_type tracker = new();
   bit calm = 1'b0;
   int points_sent = 0;
   int settings_used = 0;

   hilbert_index_encoder i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_coord_0       (req_coord_0),
      .req_coord_1       (req_coord_1),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hilbert_index (rsp_hilbert_index),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) tracker.note_point(req_coord_0, req_coord_1);
      if (!reset && rsp_valid && !rsp_stall) tracker.check_index(rsp_hilbert_index);
   end

   // Valid stays high across back-to-back beats; only a gap lowers it.
   task automatic send_point(logic [hie_pkg::COORD_W-1:0] c0,
                             logic [hie_pkg::COORD_W-1:0] c1);
      req_valid   <= 1'b1;
      req_coord_0 <= c0;
      req_coord_1 <= c1;
      do @(posedge clock); while (req_stall);
      points_sent++;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_index.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [hie_pkg::CSR_ADDR_W-1:0] addr,
                            logic [hie_pkg::CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.write_reg(addr, data);
      if (addr == DIMS_ADDR) settings_used++;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check_dims();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= DIMS_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {{(hie_pkg::CSR_DATA_W - hie_pkg::DIMS_W){1'b0}}, tracker.dims}) begin
         $error("dims_used expected %0d actual %h", tracker.dims, csr_prdata);
         tracker.mismatches++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Full-range values half of the time, corner patterns the rest.
   function automatic logic [hie_pkg::COORD_W-1:0] pick_coord();
      logic [hie_pkg::COORD_W-1:0] one_hot;
      one_hot = 32'd1 << $urandom_range(0, hie_pkg::COORD_W - 1);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return $urandom_range(0, 15);
         3: return one_hot;
         4: return ~one_hot;
         default: return $urandom;
      endcase
   endfunction

   // The receiver stalls in bursts until the closing phase.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      logic [hie_pkg::CSR_DATA_W-1:0] word;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_coord_0 <= '0;
      req_coord_1 <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Two dimensions out of reset.
      csr_check_dims();
      send_point('0, '0);
      send_point('1, '1);
      send_point('1, '0);
      send_point('0, '1);
      send_point(32'd1, 32'd0);
      send_point(32'd0, 32'd1);
      send_point(32'h8000_0000, 32'h0000_0000);
      send_point(32'h0000_0000, 32'h8000_0000);
      send_point(32'hAAAA_AAAA, 32'h5555_5555);
      send_point(32'h5555_5555, 32'hAAAA_AAAA);

      // One dimension: the second coordinate must have no effect.
      wait_idle();
      csr_write(DIMS_ADDR, ($urandom & ~32'd3) | 32'd1);
      csr_check_dims();
      send_point('0, '1);
      send_point('1, $urandom);
      send_point(32'h8000_0000, $urandom);
      send_point(32'd1, $urandom);

      // A zero count acts as one dimension, three as two.
      wait_idle();
      csr_write(DIMS_ADDR, 32'd0);
      csr_check_dims();
      send_point('1, $urandom);
      send_point(32'h1234_5678, $urandom);
      wait_idle();
      csr_write(DIMS_ADDR, 32'hFFFF_FFFF);
      csr_check_dims();
      send_point('1, 32'd0);
      send_point(32'h1234_5678, 32'h9ABC_DEF0);

      // A write to an address past the register list changes nothing.
      wait_idle();
      csr_write(UNUSED_ADDR, 32'd1);
      csr_check_dims();
      send_point(32'hDEAD_BEEF, 32'hCAFE_F00D);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_idle();
         word = $urandom;
         if (p == RANDOM_PHASES - 1) begin
            calm = 1'b1;
            word[hie_pkg::DIMS_W-1:0] = 2'd2;
         end else if (p < 4) begin
            word[hie_pkg::DIMS_W-1:0] = 2'd1 + p[1:0];
         end
         csr_write(DIMS_ADDR, word);
         if ($urandom_range(0, 2) == 0) csr_write(UNUSED_ADDR, $urandom);
         csr_check_dims();
         for (int k = 0; k < PHASE_POINTS; k++) send_point(pick_coord(), pick_coord());
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d points across %0d dims_used settings; %0d indexes checked.",
               points_sent, settings_used, tracker.checked);
      if (tracker.mismatches == 0 && tracker.pending_index.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Timed out with %0d indexes outstanding.", tracker.pending_index.size());
      $display("FAIL");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/hie_pkg.sv
hw/rtl/hie_cell.sv
hw/rtl/hie_finish.sv
hw/rtl/hilbert_index_encoder.sv
tb/tb_top.sv
